// File: rtl/core/qthp_pkg.sv
// Package for the quaternion to heading and pitch block.
// Holds the item structs, the arctangent table and fixed constants; no dependencies.
`timescale 1ns / 1ps
package qthp_pkg;

   typedef struct packed {
      logic signed [15:0] q_x;
      logic signed [15:0] q_y;
      logic signed [15:0] q_z;
      logic signed [15:0] q_w;
   } req_type;

   typedef struct packed {
      logic signed [15:0] heading_angle;
      logic signed [15:0] pitch_angle;
   } rsp_type;

   localparam int AtanEntries = 24;
   localparam int VecWidth = 52;
   localparam int AngWidth = 34;
   localparam logic signed [AngWidth-1:0] HalfPiQ30 = 34'sd1686629713;
   localparam logic signed [31:0] DegPerRadQ24 = 32'sd961263669;
   localparam logic signed [15:0] RadLimit = 16'sd25736;
   localparam logic signed [15:0] DegLimit = 16'sd23040;

   function automatic logic signed [AngWidth-1:0] atan_q30(input int idx);
      logic [31:0] v;
      case (idx)
         0: v = 32'h3243F6A8;  1: v = 32'h1DAC6705;  2: v = 32'h0FADBAFC;
         3: v = 32'h07F56EA6;  4: v = 32'h03FEAB76;  5: v = 32'h01FFD55B;
         6: v = 32'h00FFFAAA;  7: v = 32'h007FFF55;  8: v = 32'h003FFFEA;
         9: v = 32'h001FFFFD; 10: v = 32'h000FFFFF; 11: v = 32'h0007FFFF;
         12: v = 32'h0003FFFF; 13: v = 32'h0001FFFF; 14: v = 32'h0000FFFF;
         15: v = 32'h00007FFF; 16: v = 32'h00003FFF; 17: v = 32'h00001FFF;
         18: v = 32'h00000FFF; 19: v = 32'h000007FF; 20: v = 32'h000003FF;
         21: v = 32'h000001FF; 22: v = 32'h000000FF; 23: v = 32'h0000007F;
         default: v = 32'h0;
      endcase
      return {2'b00, v};
   endfunction

endpackage

// File: rtl/core/quaternion_to_heading_pitch.sv
// Quaternion to heading and pitch angles, fully pipelined.
// Uses qthp_pkg, qthp_terms, qthp_cordic and qthp_scale.
// Channels: req_ carries a quaternion item in signed Q1.15, taken when start
// is high and busy is low; busy is always low, so an item can enter in
// every cycle. Each item gives one rsp_ item, shown for one cycle with
// rsp_strobe, in input order. The csr_ port writes degree_mode (reset 1):
// 1 gives Q8.7 degrees, 0 gives Q3.13 radians; it is always ready.
// The item passes Stages + 5 registers, where Stages is CORDIC_STAGES capped
// at 24: two for the products and sums, one for the prerotation, one per
// CORDIC iteration and two for scaling. Throughput is one item per cycle,
// set by the pipeline.
// Reset clears the valid bits and sets degree_mode; no item is in flight
// after it. The receiver cannot stall, so results are never held.
// Change degree_mode only while no item is in flight.
`timescale 1ns / 1ps
module quaternion_to_heading_pitch #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qthp_pkg::req_type req_item,
   output logic              rsp_strobe,
   output qthp_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data
);
   import qthp_pkg::*;

   localparam int Stages = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;
   localparam int TailDepth = Stages + 3;

   logic                       deg_ff;
   logic                       tv_ff [TailDepth];
   logic                       terms_valid;
   logic signed [34:0]         hx, hy, px, py;
   logic signed [AngWidth-1:0] h_ang, p_ang;
   logic signed [15:0]         h_out, p_out;

   assign busy = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) deg_ff <= 1'b1;
      else if (csr_valid && csr_ready) deg_ff <= csr_data;
   end

   qthp_terms u_terms (
      .clock(clock), .reset(reset), .in_valid(start && !busy), .in_item(req_item),
      .out_valid(terms_valid), .h_x(hx), .h_y(hy), .p_x(px), .p_y(py)
   );

   qthp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_h (
      .clock(clock), .in_x(hx), .in_y(hy), .out_angle(h_ang)
   );

   qthp_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic_p (
      .clock(clock), .in_x(px), .in_y(py), .out_angle(p_ang)
   );

   qthp_scale u_scale_h (
      .clock(clock), .degree_mode(deg_ff), .in_angle(h_ang), .out_angle(h_out)
   );

   qthp_scale u_scale_p (
      .clock(clock), .degree_mode(deg_ff), .in_angle(p_ang), .out_angle(p_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TailDepth; i++) tv_ff[i] <= 1'b0;
      end else begin
         tv_ff[0] <= terms_valid;
         for (int i = 1; i < TailDepth; i++) tv_ff[i] <= tv_ff[i-1];
      end
   end

   assign rsp_strobe = tv_ff[TailDepth-1];
   assign rsp_item.heading_angle = h_out;
   assign rsp_item.pitch_angle = p_out;
endmodule

// File: rtl/core/qthp_terms.sv
// Product stages forming the two atan2 argument vectors from a quaternion.
// Uses qthp_pkg; two register stages (products, then sums).
`timescale 1ns / 1ps
module qthp_terms (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  qthp_pkg::req_type    in_item,
   output logic                 out_valid,
   output logic signed [34:0]   h_x,
   output logic signed [34:0]   h_y,
   output logic signed [34:0]   p_x,
   output logic signed [34:0]   p_y
);
   import qthp_pkg::*;

   logic signed [31:0] sx_ff, sy_ff, sz_ff, sw_ff, xy_ff, wz_ff, wx_ff, yz_ff;
   logic               v1_ff, v2_ff;
   logic signed [34:0] hx_ff, hy_ff, px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      sx_ff <= 32'(in_item.q_x) * 32'(in_item.q_x);
      sy_ff <= 32'(in_item.q_y) * 32'(in_item.q_y);
      sz_ff <= 32'(in_item.q_z) * 32'(in_item.q_z);
      sw_ff <= 32'(in_item.q_w) * 32'(in_item.q_w);
      xy_ff <= 32'(in_item.q_x) * 32'(in_item.q_y);
      wz_ff <= 32'(in_item.q_w) * 32'(in_item.q_z);
      wx_ff <= 32'(in_item.q_w) * 32'(in_item.q_x);
      yz_ff <= 32'(in_item.q_y) * 32'(in_item.q_z);
      hy_ff <= (35'(xy_ff) + 35'(wz_ff)) <<< 1;
      hx_ff <= 35'(sw_ff) + 35'(sx_ff) - 35'(sy_ff) - 35'(sz_ff);
      py_ff <= (35'(wx_ff) + 35'(yz_ff)) <<< 1;
      px_ff <= 35'(sw_ff) - 35'(sx_ff) - 35'(sy_ff) + 35'(sz_ff);
   end

   assign out_valid = v2_ff;
   assign h_x = hx_ff;
   assign h_y = hy_ff;
   assign p_x = px_ff;
   assign p_y = py_ff;
endmodule

// File: rtl/core/qthp_cordic.sv
// Pipelined vectoring CORDIC giving the angle of (x, y) in radians Q.30.
// Uses qthp_pkg; one register stage for prerotation and one per iteration.
`timescale 1ns / 1ps
module qthp_cordic #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic                                   clock,
   input  logic signed [34:0]                     in_x,
   input  logic signed [34:0]                     in_y,
   output logic signed [qthp_pkg::AngWidth-1:0]   out_angle
);
   import qthp_pkg::*;

   localparam int Stages = (CORDIC_STAGES < AtanEntries) ? CORDIC_STAGES : AtanEntries;

   logic signed [VecWidth-1:0] x_ff [Stages+1];
   logic signed [VecWidth-1:0] y_ff [Stages+1];
   logic signed [AngWidth-1:0] z_ff [Stages+1];
   logic                       zero_ff [Stages+1];

   logic signed [VecWidth-1:0] x_in, y_in;
   logic signed [AngWidth-1:0] z_in;

   always_comb begin
      x_in = VecWidth'(in_x) <<< 16;
      y_in = VecWidth'(in_y) <<< 16;
      z_in = '0;
      if (in_x < 0) begin
         if (in_y >= 0) begin
            x_in = VecWidth'(in_y) <<< 16;
            y_in = -(VecWidth'(in_x) <<< 16);
            z_in = HalfPiQ30;
         end else begin
            x_in = -(VecWidth'(in_y) <<< 16);
            y_in = VecWidth'(in_x) <<< 16;
            z_in = -HalfPiQ30;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0] <= x_in;
      y_ff[0] <= y_in;
      z_ff[0] <= z_in;
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
   end

   for (genvar i = 0; i < Stages; i++) begin : g_iter
      always_ff @(posedge clock) begin
         zero_ff[i+1] <= zero_ff[i];
         if (y_ff[i] >= 0) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + atan_q30(i);
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - atan_q30(i);
         end
      end
   end

   assign out_angle = zero_ff[Stages] ? '0 : z_ff[Stages];
endmodule

// File: rtl/core/qthp_scale.sv
// Output scaling of a Q.30 radian angle to Q3.13 radians or Q8.7 degrees.
// Uses qthp_pkg; two register stages (multiply, then round and clamp).
`timescale 1ns / 1ps
module qthp_scale (
   input  logic                                 clock,
   input  logic                                 degree_mode,
   input  logic signed [qthp_pkg::AngWidth-1:0] in_angle,
   output logic signed [15:0]                   out_angle
);
   import qthp_pkg::*;

   logic signed [65:0] prod_ff;
   logic signed [AngWidth-1:0] ang_ff;
   logic               deg_ff;
   logic signed [15:0] res_ff;
   logic signed [65:0] dsum;
   logic signed [18:0] dr;
   logic signed [AngWidth:0] rsum;
   logic signed [17:0] rr;
   logic signed [15:0] res_in;

   always_comb begin
      dsum = prod_ff + (66'sd1 <<< 46);
      dr = 19'(dsum >>> 47);
      rsum = (AngWidth+1)'(ang_ff) + (35'sd1 <<< 16);
      rr = 18'(rsum >>> 17);
      if (deg_ff) begin
         if (dr > 19'(DegLimit)) res_in = DegLimit;
         else if (dr < -19'(DegLimit)) res_in = -DegLimit;
         else res_in = 16'(dr);
      end else begin
         if (rr > 18'(RadLimit)) res_in = RadLimit;
         else if (rr < -18'(RadLimit)) res_in = -RadLimit;
         else res_in = 16'(rr);
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= 66'(in_angle) * 66'(DegPerRadQ24);
      ang_ff <= in_angle;
      deg_ff <= degree_mode;
      res_ff <= res_in;
   end

   assign out_angle = res_ff;
endmodule

// File: rtl/core/qthp_checker.sv
// Port checker for the quaternion to heading and pitch block, bound to the top level.
// Uses qthp_pkg for the item types.
`timescale 1ns / 1ps
module qthp_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_strobe,
   input qthp_pkg::rsp_type rsp_item
);
   import qthp_pkg::*;

   a_busy_low: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy rose");
   a_no_spurious: assert property (@(posedge clock) $past(reset) && !reset |-> !rsp_strobe)
      else $error("strobe right after reset");
   a_heading_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.heading_angle <= RadLimit &&
                      rsp_item.heading_angle >= -RadLimit))
      else $error("heading out of range");
   a_pitch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.pitch_angle <= RadLimit &&
                      rsp_item.pitch_angle >= -RadLimit))
      else $error("pitch out of range");
endmodule

bind quaternion_to_heading_pitch qthp_checker u_qthp_checker (
   .clock(clock), .reset(reset), .busy(busy),
   .rsp_strobe(rsp_strobe), .rsp_item(rsp_item)
);
